### rtl/adfm_pkg.sv
`timescale 1ns / 1ps

package adfm_pkg;

  // PDU framing
  localparam int MAX_PDU_BYTES = 39;
  localparam int MIN_PDU_LEN   = 8;
  localparam int HEADER_BYTES  = 2;
  localparam int ADDR_BYTES    = 6;
  localparam int DATA_START    = HEADER_BYTES + ADDR_BYTES;
  localparam int MAX_PDU_LEN   = MAX_PDU_BYTES - HEADER_BYTES;

  // Field and counter widths
  localparam int BYTE_W       = 8;
  localparam int CNT_W        = 6;
  localparam int FLEN_W       = 5;
  localparam int WORD_W       = 64;
  localparam int FILTER_WORDS = 4;
  localparam int FILTER_W     = WORD_W * FILTER_WORDS;
  localparam int CFG_IDX_W    = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_LEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_WORD0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_WORD1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_WORD2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_WORD3 = 3'd4;

  typedef enum logic [2:0] {
    ST_MATCH        = 3'd0,
    ST_BAD_LEN      = 3'd1,
    ST_EMPTY_FILTER = 3'd2,
    ST_MALFORMED    = 3'd3,
    ST_NONE         = 3'd4,
    ST_TRUNCATED    = 3'd5
  } status_t;

  typedef struct packed {
    logic    matched;
    status_t status;
  } result_t;

endpackage

### rtl/adfm_cfg.sv
`timescale 1ns / 1ps

module adfm_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [adfm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [adfm_pkg::WORD_W-1:0]      cfg_data,
  output logic [adfm_pkg::FLEN_W-1:0]      filter_len,
  output logic [adfm_pkg::FILTER_W-1:0]    filter_bytes
);
  import adfm_pkg::*;

  logic [WORD_W-1:0] filter_word0;
  logic [WORD_W-1:0] filter_word1;
  logic [WORD_W-1:0] filter_word2;
  logic [WORD_W-1:0] filter_word3;

  // Writes to indexes past the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_len   <= '0;
      filter_word0 <= '0;
      filter_word1 <= '0;
      filter_word2 <= '0;
      filter_word3 <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FILTER_LEN:   filter_len   <= cfg_data[FLEN_W-1:0];
        CFG_FILTER_WORD0: filter_word0 <= cfg_data;
        CFG_FILTER_WORD1: filter_word1 <= cfg_data;
        CFG_FILTER_WORD2: filter_word2 <= cfg_data;
        CFG_FILTER_WORD3: filter_word3 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign filter_bytes = {filter_word3, filter_word2, filter_word1, filter_word0};

endmodule

### rtl/adfm_parse.sv
`timescale 1ns / 1ps

module adfm_parse (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [adfm_pkg::BYTE_W-1:0]    pkt_byte,
  input  logic                           last_byte,
  input  logic [adfm_pkg::FLEN_W-1:0]    filter_len,
  input  logic [adfm_pkg::FILTER_W-1:0]  filter_bytes,
  output logic                           res_valid,
  input  logic                           res_free,
  output adfm_pkg::result_t              res
);
  import adfm_pkg::*;

  // Input register
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_last;
  logic              s1_adv;

  // Packet walk state
  logic [CNT_W-1:0]  byte_position;
  logic [CNT_W-1:0]  data_bytes_left;
  logic [CNT_W-1:0]  element_bytes_left;
  logic [FLEN_W-1:0] compare_index;
  logic              compare_ok;
  logic              decided;
  status_t           decision_status;

  logic [CNT_W-1:0]  byte_position_next;
  logic [CNT_W-1:0]  data_bytes_left_next;
  logic [CNT_W-1:0]  element_bytes_left_next;
  logic [FLEN_W-1:0] compare_index_next;
  logic              compare_ok_next;
  logic              decided_next;
  status_t           decision_status_next;

  logic [BYTE_W-1:0] filter_byte;
  logic [BYTE_W-1:0] len_minus_addr;

  // The held word leaves unless it is a last word and the result register is full and stalled.
  assign s1_adv    = s1_valid && (!s1_last || res_free);
  assign in_stall  = s1_valid && !s1_adv;
  assign res_valid = s1_valid && s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte <= pkt_byte;
      s1_last <= last_byte;
    end
  end

  assign filter_byte    = filter_bytes[{compare_index, 3'b000} +: BYTE_W];
  assign len_minus_addr = s1_byte - BYTE_W'(ADDR_BYTES);

  always_comb begin
    byte_position_next      = byte_position;
    data_bytes_left_next    = data_bytes_left;
    element_bytes_left_next = element_bytes_left;
    compare_index_next      = compare_index;
    compare_ok_next         = compare_ok;
    decided_next            = decided;
    decision_status_next    = decision_status;

    if (!decided) begin
      if (byte_position == CNT_W'(1)) begin
        if (s1_byte < BYTE_W'(MIN_PDU_LEN) || s1_byte > BYTE_W'(MAX_PDU_LEN)) begin
          decided_next         = 1'b1;
          decision_status_next = ST_BAD_LEN;
        end else if (filter_len == '0) begin
          decided_next         = 1'b1;
          decision_status_next = ST_EMPTY_FILTER;
        end else begin
          data_bytes_left_next = len_minus_addr[CNT_W-1:0];
        end
      end else if (byte_position >= CNT_W'(DATA_START)) begin
        if (element_bytes_left == '0) begin
          // Element length byte
          if (s1_byte == '0 ||
              ({1'b0, s1_byte} + 9'd1) > {3'b000, data_bytes_left} ||
              {3'b000, filter_len} > s1_byte) begin
            decided_next         = 1'b1;
            decision_status_next = ST_MALFORMED;
          end else begin
            element_bytes_left_next = s1_byte[CNT_W-1:0];
            compare_index_next      = '0;
            compare_ok_next         = 1'b1;
            data_bytes_left_next    = data_bytes_left - CNT_W'(1);
          end
        end else begin
          data_bytes_left_next    = data_bytes_left - CNT_W'(1);
          element_bytes_left_next = element_bytes_left - CNT_W'(1);
          if (compare_index < filter_len) begin
            if (s1_byte != filter_byte) begin
              compare_ok_next = 1'b0;
            end
            compare_index_next = compare_index + FLEN_W'(1);
          end
          if (compare_index_next >= filter_len && compare_ok_next) begin
            decided_next         = 1'b1;
            decision_status_next = ST_MATCH;
          end else if (element_bytes_left_next == '0) begin
            // A single byte left at an element boundary cannot hold an element.
            if (data_bytes_left_next == '0) begin
              decided_next         = 1'b1;
              decision_status_next = ST_NONE;
            end else if (data_bytes_left_next == CNT_W'(1)) begin
              decided_next         = 1'b1;
              decision_status_next = ST_MALFORMED;
            end
          end
        end
      end
    end

    if (byte_position != '1) begin
      byte_position_next = byte_position + CNT_W'(1);
    end

    if (decided_next) begin
      res.matched = (decision_status_next == ST_MATCH);
      res.status  = decision_status_next;
    end else begin
      res.matched = 1'b0;
      res.status  = ST_TRUNCATED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      data_bytes_left    <= '0;
      element_bytes_left <= '0;
      compare_index      <= '0;
      compare_ok         <= 1'b0;
      decided            <= 1'b0;
      decision_status    <= ST_MATCH;
    end else if (s1_adv) begin
      if (s1_last) begin
        byte_position      <= '0;
        data_bytes_left    <= '0;
        element_bytes_left <= '0;
        compare_index      <= '0;
        compare_ok         <= 1'b0;
        decided            <= 1'b0;
        decision_status    <= ST_MATCH;
      end else begin
        byte_position      <= byte_position_next;
        data_bytes_left    <= data_bytes_left_next;
        element_bytes_left <= element_bytes_left_next;
        compare_index      <= compare_index_next;
        compare_ok         <= compare_ok_next;
        decided            <= decided_next;
        decision_status    <= decision_status_next;
      end
    end
  end

endmodule

### rtl/adfm_outreg.sv
`timescale 1ns / 1ps

module adfm_outreg (
  input  logic               clk,
  input  logic               rst,
  input  logic               res_valid,
  output logic               res_free,
  input  adfm_pkg::result_t  res,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               matched,
  output logic [2:0]         status
);
  import adfm_pkg::*;

  result_t held;

  assign res_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res_valid) begin
      held <= res;
    end
  end

  assign matched = held.matched;
  assign status  = held.status;

endmodule

### rtl/ble_adv_data_filter_match_top.sv
`timescale 1ns / 1ps
// Channel  | Handshake              | Word
// ---------+------------------------+--------------------------------------
// input    | in_valid / in_stall    | pkt_byte[7:0], last_byte
// output   | out_valid / out_stall  | matched, status[2:0]
// config   | cfg_valid / cfg_ready  | cfg_index[2:0], cfg_data[63:0]
//
// One byte is taken every cycle unless the input stalls; each byte is held in the input
// register, where the counter and compare update is made.
// A result enters the output register as its last byte leaves the input register.
// Input stalls only while a last byte waits behind a stalled result.
// Synchronous reset clears the filter registers and the packet state.

module ble_adv_data_filter_match_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [adfm_pkg::BYTE_W-1:0]    pkt_byte,
  input  logic                           last_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           matched,
  output logic [2:0]                     status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [adfm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [adfm_pkg::WORD_W-1:0]    cfg_data
);
  import adfm_pkg::*;

  logic [FLEN_W-1:0]   filter_len;
  logic [FILTER_W-1:0] filter_bytes;
  logic                res_valid;
  logic                res_free;
  result_t             res;

  assign cfg_ready = 1'b1;

  adfm_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .filter_len   (filter_len),
    .filter_bytes (filter_bytes)
  );

  adfm_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pkt_byte     (pkt_byte),
    .last_byte    (last_byte),
    .filter_len   (filter_len),
    .filter_bytes (filter_bytes),
    .res_valid    (res_valid),
    .res_free     (res_free),
    .res          (res)
  );

  adfm_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_free  (res_free),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .matched   (matched),
    .status    (status)
  );

endmodule

### rtl/adfm_chk.sv
`timescale 1ns / 1ps

module adfm_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           matched,
  input logic [2:0]                     status
);
  import adfm_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(matched) && $stable(status))
    else $error("result word changed while stalled");

  // The match flag agrees with the status code.
  a_match_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> matched == (status == ST_MATCH))
    else $error("matched disagrees with status");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_TRUNCATED)
    else $error("status out of range");

  // Input back-pressure only comes from a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("reset did not clear the handshakes");

endmodule

bind ble_adv_data_filter_match_top adfm_chk u_adfm_chk (.*);

### dv/adfm_verdict_check.sv
`timescale 1ns / 1ps

module adfm_verdict_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [adfm_pkg::BYTE_W-1:0]    pkt_byte,
  input  logic                           last_byte,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           matched,
  input  logic [2:0]                     status,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [adfm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [adfm_pkg::WORD_W-1:0]    cfg_data,
  output int                             verdicts_owed,
  output int                             mismatches
);
  import adfm_pkg::*;

  logic [FLEN_W-1:0] flt_len;
  logic [WORD_W-1:0] flt_word [FILTER_WORDS];

  logic [CNT_W-1:0]  byte_pos;
  logic [CNT_W-1:0]  data_left;
  logic [CNT_W-1:0]  elem_left;
  logic [FLEN_W-1:0] cmp_idx;
  logic              cmp_ok;
  logic              decided;
  status_t           decision;

  result_t verdict_q [$];
  int      errs = 0;

  function automatic logic [7:0] filter_byte(input logic [FLEN_W-1:0] idx);
    return flt_word[idx[4:3]][idx[2:0]*8 +: 8];
  endfunction

  task automatic clear_walk();
    byte_pos = '0;
    data_left = '0;
    elem_left = '0;
    cmp_idx = '0;
    cmp_ok = 1'b0;
    decided = 1'b0;
    decision = ST_MATCH;
  endtask

  task automatic decide(input status_t st);
    decided = 1'b1;
    decision = st;
  endtask

  // One byte of the element chain: either an element length or element content.
  task automatic take_data_byte(input logic [7:0] b);
    int n;
    n = b;
    if (elem_left == 0) begin
      if (n == 0 || n + 1 > data_left || flt_len > n) begin
        decide(ST_MALFORMED);
      end else begin
        elem_left = b[CNT_W-1:0];
        cmp_idx = '0;
        cmp_ok = 1'b1;
        data_left = data_left - 1'b1;
      end
    end else begin
      data_left = data_left - 1'b1;
      elem_left = elem_left - 1'b1;
      if (cmp_idx < flt_len) begin
        if (b != filter_byte(cmp_idx)) cmp_ok = 1'b0;
        cmp_idx = cmp_idx + 1'b1;
      end
      if (cmp_idx >= flt_len && cmp_ok) begin
        decide(ST_MATCH);
      end else if (elem_left == 0) begin
        if (data_left == 0) decide(ST_NONE);
        else if (data_left == 1) decide(ST_MALFORMED);
      end
    end
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic fin);
    result_t r;
    if (!decided) begin
      if (byte_pos == 1) begin
        if (b < MIN_PDU_LEN || b > MAX_PDU_LEN) decide(ST_BAD_LEN);
        else if (flt_len == 0) decide(ST_EMPTY_FILTER);
        else data_left = CNT_W'(b - ADDR_BYTES);
      end else if (byte_pos >= DATA_START) begin
        take_data_byte(b);
      end
    end
    if (byte_pos != '1) byte_pos = byte_pos + 1'b1;
    if (fin) begin
      r.matched = decided && decision == ST_MATCH;
      r.status = decided ? decision : ST_TRUNCATED;
      verdict_q.push_back(r);
      clear_walk();
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      flt_len = '0;
      for (int i = 0; i < FILTER_WORDS; i++) flt_word[i] = '0;
      clear_walk();
      verdict_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FILTER_LEN:   flt_len = cfg_data[FLEN_W-1:0];
          CFG_FILTER_WORD0: flt_word[0] = cfg_data;
          CFG_FILTER_WORD1: flt_word[1] = cfg_data;
          CFG_FILTER_WORD2: flt_word[2] = cfg_data;
          CFG_FILTER_WORD3: flt_word[3] = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          errs++;
          $display("%0t: result word with none expected: matched %0b status %0d",
                   $time, matched, status);
        end else begin
          want = verdict_q.pop_front();
          if (matched !== want.matched) begin
            errs++;
            $display("%0t: matched expected %0b actual %0b", $time, want.matched, matched);
          end
          if (status !== want.status) begin
            errs++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          end
        end
      end
      if (in_valid && !in_stall) absorb_byte(pkt_byte, last_byte);
    end
    verdicts_owed <= verdict_q.size();
    mismatches <= errs;
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import adfm_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int ROUND_BYTES  = 56;

  typedef logic [7:0] byte_q_t [$];

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    pkt_byte = '0;
  logic                 last_byte = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 matched;
  logic [2:0]           status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data = '0;
  int                   verdicts_owed;
  int                   mismatches;

  int   cycles = 0;
  logic quiet = 1'b0;
  int   hold_req = 0;
  int   hold_ack = 0;
  int   hold_left = 0;

  // Filter as last programmed, used to build packets that reach deep into the walk.
  logic [FLEN_W-1:0] gen_len = '0;
  logic [7:0]        gen_flt [32];
  int                bytes_sent = 0;
  int                pkts_sent = 0;

  ble_adv_data_filter_match_top i_dut (.*);
  adfm_verdict_check i_check (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 36);
    end
  end

  function automatic logic [FILTER_W-1:0] rand_filter();
    logic [FILTER_W-1:0] v;
    for (int i = 0; i < FILTER_W / 32; i++) v[i*32 +: 32] = $urandom;
    return v;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_filter(input logic [FLEN_W-1:0] len, input logic [FILTER_W-1:0] bits);
    write_reg(CFG_FILTER_LEN, WORD_W'(len));
    write_reg(CFG_FILTER_WORD0, bits[0*WORD_W +: WORD_W]);
    write_reg(CFG_FILTER_WORD1, bits[1*WORD_W +: WORD_W]);
    write_reg(CFG_FILTER_WORD2, bits[2*WORD_W +: WORD_W]);
    write_reg(CFG_FILTER_WORD3, bits[3*WORD_W +: WORD_W]);
    cfg_valid <= 1'b0;
    gen_len = len;
    for (int i = 0; i < 32; i++) gen_flt[i] = bits[i*8 +: 8];
  endtask

  task automatic send_word(input logic [7:0] b, input logic fin);
    while (!quiet && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pkt_byte <= b;
    last_byte <= fin;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_packet(input byte_q_t pk);
    foreach (pk[i]) send_word(pk[i], i == pk.size() - 1);
    pkts_sent++;
  endtask

  // Waits until every result has come back and the input register has emptied.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // A PDU with a consistent element chain; element contents often copy the filter,
  // sometimes with a single bit flipped.
  function automatic byte_q_t well_formed();
    byte_q_t    pk;
    int         plen, rem, n, lim, flip, lo;
    logic       copy;
    logic [7:0] b;
    lo = MIN_PDU_LEN;
    if (gen_len != 0 && gen_len + 7 <= MAX_PDU_LEN && $urandom_range(1) == 1)
      lo = gen_len + 7;
    plen = $urandom_range(MAX_PDU_LEN, lo);
    pk.push_back(8'($urandom));
    pk.push_back(8'(plen));
    repeat (ADDR_BYTES) pk.push_back(8'($urandom));
    rem = plen - ADDR_BYTES;
    while (rem > 0) begin
      if (rem == 1) begin
        pk.push_back(8'($urandom));
        rem = 0;
      end else begin
        if (gen_len != 0 && gen_len <= rem - 1 && $urandom_range(2) != 0)
          n = $urandom_range(rem - 1, gen_len);
        else
          n = $urandom_range(rem - 1, 1);
        pk.push_back(8'(n));
        copy = $urandom_range(3) != 0;
        lim = (n < gen_len) ? n : gen_len;
        flip = -1;
        if (lim > 0 && $urandom_range(2) == 0) flip = $urandom_range(lim - 1, 0);
        for (int i = 0; i < n; i++) begin
          if (copy && i < gen_len) begin
            b = gen_flt[i];
            if (i == flip) b = b ^ (8'h01 << $urandom_range(7));
          end else begin
            b = 8'($urandom);
          end
          pk.push_back(b);
        end
        rem = rem - n - 1;
      end
    end
    return pk;
  endfunction

  task automatic random_packet();
    byte_q_t pk;
    int      sel, cut;
    sel = $urandom_range(99);
    if (sel < 10) begin
      repeat ($urandom_range(10, 1)) pk.push_back(8'($urandom));
    end else begin
      pk = well_formed();
      if (sel < 20) pk[$urandom_range(pk.size() - 1, 1)] = 8'($urandom);
      sel = $urandom_range(99);
      if (sel < 15) begin
        repeat ($urandom_range(3, 1)) pk.push_back(8'($urandom));
      end else if (sel < 30) begin
        cut = $urandom_range(pk.size() - 1, 1);
        while (pk.size() > cut) void'(pk.pop_back());
      end
    end
    send_packet(pk);
  endtask

  initial begin
    logic [FILTER_W-1:0] bits;
    logic [7:0]          t;
    int                  start_b, start_p;

    for (int i = 0; i < 32; i++) gen_flt[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Filter is empty out of reset.
    send_packet('{8'hFF});
    send_packet('{8'h00, 8'd8});
    settle();

    bits = rand_filter();
    set_filter(5'd1, bits);
    t = gen_flt[0];
    send_packet('{8'h40, 8'd7});
    send_packet('{8'h40, 8'd38});
    send_packet('{8'h40, 8'hFF});
    send_packet('{8'h02, 8'd8});
    send_packet('{8'h00, 8'd8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd1, t});
    // Bytes past the declared length are ignored.
    send_packet('{8'hFF, 8'd8, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd1, t,
                  8'hFF, 8'h00});
    send_packet('{8'h02, 8'd8, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'd1, t ^ 8'h80});
    send_packet('{8'h02, 8'd8, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'd0, t});
    send_packet('{8'h02, 8'd8, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'd2, t});
    // A single data byte left over at an element boundary.
    send_packet('{8'h02, 8'd9, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'd1,
                  t ^ 8'h01, 8'h55});
    settle();

    // An element shorter than the filter stops the walk.
    set_filter(5'd2, bits);
    send_packet('{8'h02, 8'd9, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'd1, t, 8'h00});
    settle();

    for (int round = 0; round < 8; round++) begin
      bits = rand_filter();
      case (round)
        0:       set_filter(5'd31, '1);
        1:       set_filter(5'd0, bits);
        2:       set_filter(5'd30, bits);
        3:       set_filter(5'd1, '0);
        default: set_filter(5'($urandom_range(8, 1)), bits);
      endcase
      if (round == 4) quiet <= 1'b1;
      if (round == 5) begin
        // Results pile up behind the long hold-off until the input stalls.
        hold_req <= hold_req + 1;
        repeat (12) send_packet('{8'($urandom), 8'd7});
      end
      start_b = bytes_sent;
      start_p = pkts_sent;
      while (bytes_sent - start_b < ROUND_BYTES || pkts_sent - start_p < 6) random_packet();
      settle();
      quiet <= 1'b0;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
